// File: sv/smp_pkg.sv
// Shared types, constants and helpers of the STUN message parser.
// Used by smp_parser, smp_rec_fifo and stun_message_parser.
package smp_pkg;

  localparam logic [31:0] COOKIE         = 32'h2112A442;
  localparam logic [15:0] MATCH_PORT_RST = 16'd3478;
  localparam logic [15:0] HDR_BYTES      = 16'd20;
  localparam int          ATTR_LIMIT     = 32;
  localparam int          USERNAME_CAP   = 255;
  localparam logic [15:0] ATYPE_USER     = 16'h0006;
  localparam logic [15:0] ATYPE_XMAP     = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4    = 8'h01;
  localparam int          FIFO_DEPTH     = 8;
  localparam int          FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int          RUN_MAX        = 4;

  localparam logic [2:0] K_TYPE    = 3'd0;
  localparam logic [2:0] K_TXID_HI = 3'd1;
  localparam logic [2:0] K_TXID_LO = 3'd2;
  localparam logic [2:0] K_USER_B  = 3'd3;
  localparam logic [2:0] K_USER_E  = 3'd4;
  localparam logic [2:0] K_IPV4    = 3'd5;
  localparam logic [2:0] K_OVERRUN = 3'd6;
  localparam logic [2:0] K_VERDICT = 3'd7;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_AHDR   = 5'b00010,
    PH_VALUE  = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [15:0] aux;
    logic        last;
  } rec_t;

  // records caused by one item
  typedef struct packed {
    logic [2:0]       cnt;
    rec_t [3:0]       recs;
  } run_t;

  function automatic run_t push_rec(run_t r, logic [2:0] kind, logic [63:0] value,
                                    logic [15:0] aux);
    run_t o;
    o = r;
    if (r.cnt < 3'(RUN_MAX)) begin
      if (r.cnt != 3'd0) o.recs[2'(r.cnt - 3'd1)].last = 1'b0;
      o.recs[r.cnt[1:0]].kind  = kind;
      o.recs[r.cnt[1:0]].value = value;
      o.recs[r.cnt[1:0]].aux   = aux;
      o.recs[r.cnt[1:0]].last  = 1'b1;
      o.cnt = r.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic logic [15:0] name_code(logic [15:0] t);
    logic [15:0] c;
    case (t)
      16'h0001: c = 16'd1;
      16'h0101: c = 16'd2;
      16'h0111: c = 16'd3;
      16'h0011: c = 16'd4;
      16'h0003: c = 16'd5;
      16'h0103: c = 16'd6;
      16'h0113: c = 16'd7;
      16'h0004: c = 16'd8;
      16'h0104: c = 16'd9;
      16'h0006: c = 16'd10;
      16'h0007: c = 16'd11;
      16'h0008: c = 16'd12;
      16'h0108: c = 16'd13;
      16'h0009: c = 16'd14;
      16'h0109: c = 16'd15;
      default:  c = 16'd0;
    endcase
    return c;
  endfunction

endpackage

// File: sv/smp_parser.sv
// Per-byte header and attribute walk of the STUN message parser.
// Holds the packet state and builds the records of each item. Uses smp_pkg.
module smp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_packet,
  input  logic [15:0]      destination_port,
  input  logic [15:0]      match_port,
  output smp_pkg::run_t    run
);
  import smp_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] mtype_r, mtype_nxt;
  logic [15:0] mlen_r, mlen_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic        hvalid_r, hvalid_nxt;
  logic [31:0] txu_r, txu_nxt;
  logic [63:0] txl_r, txl_nxt;
  logic [31:0] ash_r, ash_nxt;
  logic [15:0] left_r, left_nxt;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  seen_r, seen_nxt;
  logic [7:0]  ucnt_r, ucnt_nxt;
  logic [7:0]  fam_r, fam_nxt;
  logic [47:0] macc_r, macc_nxt;

  logic [16:0] end_pos;
  logic [15:0] alen;
  logic [15:0] off;
  logic [1:0]  pad;
  logic        fin;
  logic [16:0] plen;
  logic [1:0]  verdict;

  always_comb begin
    pos_nxt    = pos_r;
    mtype_nxt  = mtype_r;
    mlen_nxt   = mlen_r;
    cookie_nxt = cookie_r;
    hvalid_nxt = hvalid_r;
    txu_nxt    = txu_r;
    txl_nxt    = txl_r;
    ash_nxt    = ash_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    seen_nxt   = seen_r;
    ucnt_nxt   = ucnt_r;
    fam_nxt    = fam_r;
    macc_nxt   = macc_r;
    run        = '0;
    fin        = 1'b0;
    alen       = ash_r[15:0];
    off        = 16'd0;
    pad        = 2'd0;
    end_pos    = 17'(HDR_BYTES) + {1'b0, mlen_r};
    plen       = {1'b0, pos_r} + 17'd1;
    verdict    = 2'd0;

    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r == 16'd0) begin
          if (data_byte[7:6] != 2'b00) hvalid_nxt = 1'b0;
          mtype_nxt = {data_byte, 8'h00};
        end else if (pos_r == 16'd1) begin
          mtype_nxt = {mtype_r[15:8], data_byte};
        end else if (pos_r == 16'd2) begin
          mlen_nxt = {data_byte, 8'h00};
        end else if (pos_r == 16'd3) begin
          mlen_nxt = {mlen_r[15:8], data_byte};
        end else if (pos_r < 16'd8) begin
          cookie_nxt = {cookie_r[23:0], data_byte};
        end else if (pos_r < 16'd12) begin
          txu_nxt = {txu_r[23:0], data_byte};
        end else begin
          txl_nxt = {txl_r[55:0], data_byte};
        end
        if (pos_r >= HDR_BYTES - 16'd1) begin
          run = push_rec(run, K_TYPE, {48'h0, mtype_nxt}, name_code(mtype_nxt));
          run = push_rec(run, K_TXID_HI, {32'h0, txu_nxt}, 16'h0);
          run = push_rec(run, K_TXID_LO, txl_nxt, 16'h0);
          phase_nxt = PH_AHDR;
          left_nxt  = 16'd0;
        end
      end
      PH_AHDR: begin
        if (pos_r == 16'hFFFF) begin
          phase_nxt = PH_DONE;
        end else if (left_r == 16'd0 && (seen_r >= 6'(ATTR_LIMIT) ||
                     {1'b0, pos_r} + 17'd4 > end_pos)) begin
          phase_nxt = PH_DONE;
        end else begin
          ash_nxt  = {ash_r[23:0], data_byte};
          left_nxt = left_r + 16'd1;
          if (left_r == 16'd3) begin
            alen = ash_nxt[15:0];
            if ({2'b0, pos_r} + 18'd1 + {2'b0, alen} > {1'b0, end_pos}) begin
              run = push_rec(run, K_OVERRUN, 64'h0, 16'h0);
              phase_nxt = PH_DONE;
            end else begin
              ucnt_nxt = 8'd0;
              fam_nxt  = 8'd0;
              macc_nxt = 48'd0;
              if (alen == 16'd0) begin
                fin = 1'b1;
              end else begin
                phase_nxt = PH_VALUE;
                left_nxt  = alen;
              end
            end
          end
        end
      end
      PH_VALUE: begin
        if (pos_r == 16'hFFFF) begin
          phase_nxt = PH_DONE;
        end else begin
          off = alen - left_r;
          if (ash_r[31:16] == ATYPE_USER) begin
            if (ucnt_r < 8'(USERNAME_CAP)) begin
              run = push_rec(run, K_USER_B, {56'h0, data_byte}, 16'h0);
              ucnt_nxt = ucnt_r + 8'd1;
            end
          end else if (ash_r[31:16] == ATYPE_XMAP && alen >= 16'd8) begin
            if (off == 16'd1) begin
              fam_nxt = data_byte;
            end else if (off >= 16'd2 && off <= 16'd7) begin
              macc_nxt = {macc_r[39:0], data_byte};
              if (off == 16'd7 && fam_r == FAMILY_IPV4) begin
                run = push_rec(run, K_IPV4, {32'h0, macc_nxt[31:0] ^ COOKIE},
                               macc_nxt[47:32] ^ COOKIE[31:16]);
              end
            end
          end
          left_nxt = left_r - 16'd1;
          if (left_nxt == 16'd0) fin = 1'b1;
        end
      end
      PH_PAD: begin
        if (pos_r == 16'hFFFF) begin
          phase_nxt = PH_DONE;
        end else begin
          left_nxt = left_r - 16'd1;
          if (left_nxt == 16'd0) phase_nxt = PH_AHDR;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // close the attribute: username length, padding or next header
    if (fin) begin
      if (ash_nxt[31:16] == ATYPE_USER) begin
        run = push_rec(run, K_USER_E, {56'h0, ucnt_nxt}, 16'h0);
      end
      if (seen_r < 6'd63) seen_nxt = seen_r + 6'd1;
      pad = 2'(2'd0 - ash_nxt[1:0]);
      if (pad != 2'd0) begin
        phase_nxt = PH_PAD;
        left_nxt  = {14'd0, pad};
      end else begin
        phase_nxt = PH_AHDR;
        left_nxt  = 16'd0;
      end
    end

    if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;

    if (end_of_packet) begin
      if (plen >= 17'(HDR_BYTES) && hvalid_nxt && cookie_nxt == COOKIE &&
          mlen_nxt[1:0] == 2'b00 && 17'(HDR_BYTES) + {1'b0, mlen_nxt} <= plen) begin
        verdict = (destination_port == match_port) ? 2'd2 : 2'd1;
      end
      run = push_rec(run, K_VERDICT, {62'h0, verdict}, 16'h0);
      pos_nxt    = 16'd0;
      mtype_nxt  = 16'd0;
      mlen_nxt   = 16'd0;
      cookie_nxt = 32'd0;
      hvalid_nxt = 1'b1;
      txu_nxt    = 32'd0;
      txl_nxt    = 64'd0;
      ash_nxt    = 32'd0;
      left_nxt   = 16'd0;
      phase_nxt  = PH_HEADER;
      seen_nxt   = 6'd0;
      ucnt_nxt   = 8'd0;
      fam_nxt    = 8'd0;
      macc_nxt   = 48'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 16'd0;
      mtype_r  <= 16'd0;
      mlen_r   <= 16'd0;
      cookie_r <= 32'd0;
      hvalid_r <= 1'b1;
      txu_r    <= 32'd0;
      txl_r    <= 64'd0;
      ash_r    <= 32'd0;
      left_r   <= 16'd0;
      phase_r  <= PH_HEADER;
      seen_r   <= 6'd0;
      ucnt_r   <= 8'd0;
      fam_r    <= 8'd0;
      macc_r   <= 48'd0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      mtype_r  <= mtype_nxt;
      mlen_r   <= mlen_nxt;
      cookie_r <= cookie_nxt;
      hvalid_r <= hvalid_nxt;
      txu_r    <= txu_nxt;
      txl_r    <= txl_nxt;
      ash_r    <= ash_nxt;
      left_r   <= left_nxt;
      phase_r  <= phase_nxt;
      seen_r   <= seen_nxt;
      ucnt_r   <= ucnt_nxt;
      fam_r    <= fam_nxt;
      macc_r   <= macc_nxt;
    end
  end

endmodule

// File: sv/smp_rec_fifo.sv
// Record queue of the STUN message parser: takes up to four records per
// cycle and hands out one per cycle while rd_ready is high. Uses smp_pkg.
module smp_rec_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  smp_pkg::run_t    run,
  output logic             room,
  output logic             rd_valid,
  input  logic             rd_ready,
  output smp_pkg::rec_t    rd_rec
);
  import smp_pkg::*;

  rec_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [2:0]         push_n;
  logic               pop;

  assign room     = cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - RUN_MAX);
  assign rd_valid = cnt_r != '0;
  assign rd_rec   = mem_r[rd_r];
  assign pop      = rd_valid && rd_ready;
  assign push_n   = push ? run.cnt : 3'd0;

  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(push_n);
    rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RUN_MAX; i++) begin
      if (3'(i) < push_n) mem_r[FIFO_AW'(wr_r + FIFO_AW'(i))] <= run.recs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("record queue over depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    FIFO_AW'(wr_r - rd_r) == cnt_r[FIFO_AW-1:0])
    else $error("pointer gap disagrees with count");
  a_push_fit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room) else $error("push without room for a full run");
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> cnt_r == '0) else $error("queue not empty after reset");
`endif

endmodule

// File: sv/stun_message_parser.sv
// Top level of the STUN message parser: config register, parser, record queue.
// Depends on smp_pkg, smp_parser and smp_rec_fifo.
//
// Takes one packet byte per cycle and emits binary records: header type with
// name code, transaction id, USERNAME bytes and length, un-XORed IPv4 mapped
// address, overrun warning and a per-packet verdict on the last byte. Each
// byte is parsed combinationally, so a new byte is accepted every cycle as
// long as the eight-entry record queue has room for four records; the queue
// drains one record per cycle while out_tready is high, which sets the
// sustained rate when bytes make more than one record each (the twentieth
// byte makes three, four when it also ends the packet).
module stun_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], destination_port[23:8]
  input  logic        in_tlast,   // end_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // record_value[63:0], record_aux[79:64]
  output logic [2:0]  out_tuser,  // record_kind[2:0]
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import smp_pkg::*;

  logic [15:0] match_port_r;
  logic        accept;
  logic        room;
  run_t        run;
  rec_t        head;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= MATCH_PORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      match_port_r <= cfg_data;
    end
  end

  smp_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .data_byte        (in_tdata[7:0]),
    .end_of_packet    (in_tlast),
    .destination_port (in_tdata[23:8]),
    .match_port       (match_port_r),
    .run              (run)
  );

  smp_rec_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .run      (run),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_rec   (head)
  );

  assign out_tdata = {head.aux, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// File: tb/sv/tb.sv
// Testbench for stun_message_parser: byte stream in, record stream out.
// Depends on smp_pkg and the parser RTL; predicts records with a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import smp_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [15:0] aux;
    logic        last;
  } record_t;

  class stun_scoreboard;
    record_t     pending[$];
    int          errors;
    logic [15:0] port_reg;
    logic [15:0] pos, mtype, mlen;
    logic [31:0] cookie_acc, txu, ahdr;
    logic [63:0] txl;
    logic [15:0] left;
    phase_t      phase;
    bit          hdr_ok;
    int unsigned seen;
    logic [7:0]  ucount, family;
    logic [47:0] macc;
    record_t     run[$];

    function void clear_packet();
      pos = 0; mtype = 0; mlen = 0; cookie_acc = 0; hdr_ok = 1; txu = 0; txl = 0;
      ahdr = 0; left = 0; phase = PH_HEADER; seen = 0; ucount = 0; family = 0; macc = 0;
    endfunction

    function void reset_all();
      clear_packet();
      port_reg = MATCH_PORT_RST;
      errors = 0;
    endfunction

    function void add(logic [2:0] k, logic [63:0] v, logic [15:0] a);
      record_t r;
      if (run.size() >= RUN_MAX) return;
      r.kind = k; r.value = v; r.aux = a; r.last = 0;
      run.push_back(r);
    endfunction

    function logic [15:0] type_code(logic [15:0] t);
      logic [15:0] known[15] = '{16'h0001, 16'h0101, 16'h0111, 16'h0011, 16'h0003,
                                 16'h0103, 16'h0113, 16'h0004, 16'h0104, 16'h0006,
                                 16'h0007, 16'h0008, 16'h0108, 16'h0009, 16'h0109};
      for (int i = 0; i < 15; i++) if (known[i] == t) return 16'(i + 1);
      return 0;
    endfunction

    function void close_attr();
      logic [1:0] pad;
      pad = 2'(-ahdr[15:0]);
      if (ahdr[31:16] == ATYPE_USER) add(K_USER_E, 64'(ucount), 0);
      if (seen < 63) seen++;
      if (pad != 0) begin
        phase = PH_PAD; left = 16'(pad);
      end else begin
        phase = PH_AHDR; left = 0;
      end
    endfunction

    function void walk_attrs(logic [7:0] b, int unsigned p);
      int unsigned endp, alen, off;
      logic [31:0] prt, addr;
      endp = 20 + mlen;
      if (p >= 32'hFFFF) begin
        phase = PH_DONE; return;
      end
      if (phase == PH_AHDR) begin
        if (left == 0 && (seen >= ATTR_LIMIT || p + 4 > endp)) begin
          phase = PH_DONE; return;
        end
        ahdr = {ahdr[23:0], b};
        left++;
        if (left < 4) return;
        alen = ahdr[15:0];
        if (p + 1 + alen > endp) begin
          add(K_OVERRUN, 0, 0); phase = PH_DONE; return;
        end
        ucount = 0; family = 0; macc = 0;
        if (alen == 0) close_attr();
        else begin
          phase = PH_VALUE; left = 16'(alen);
        end
      end else if (phase == PH_VALUE) begin
        alen = ahdr[15:0];
        off = alen - left;
        if (ahdr[31:16] == ATYPE_USER) begin
          if (ucount < USERNAME_CAP) begin
            add(K_USER_B, 64'(b), 0); ucount++;
          end
        end else if (ahdr[31:16] == ATYPE_XMAP && alen >= 8) begin
          if (off == 1) family = b;
          else if (off >= 2 && off <= 7) begin
            macc = {macc[39:0], b};
            if (off == 7 && family == FAMILY_IPV4) begin
              prt = 32'(macc[47:32]) ^ (COOKIE >> 16);
              addr = macc[31:0] ^ COOKIE;
              add(K_IPV4, 64'(addr), prt[15:0]);
            end
          end
        end
        left--;
        if (left == 0) close_attr();
      end else if (phase == PH_PAD) begin
        left--;
        if (left == 0) phase = PH_AHDR;
      end
    endfunction

    // note one accepted byte and queue the records it causes
    function void note_byte(logic [7:0] b, logic eop, logic [15:0] dport);
      int unsigned p, len;
      logic [63:0] verdict;
      p = pos;
      run.delete();
      if (phase == PH_HEADER) begin
        if (p == 0) begin
          if (b & 8'hC0) hdr_ok = 0;
          mtype = {b, 8'h00};
        end else if (p == 1) mtype[7:0] = b;
        else if (p == 2) mlen = {b, 8'h00};
        else if (p == 3) mlen[7:0] = b;
        else if (p < 8) cookie_acc = {cookie_acc[23:0], b};
        else if (p < 12) txu = {txu[23:0], b};
        else txl = {txl[55:0], b};
        if (p >= 19) begin
          add(K_TYPE, 64'(mtype), type_code(mtype));
          add(K_TXID_HI, 64'(txu), 0);
          add(K_TXID_LO, txl, 0);
          phase = PH_AHDR; left = 0;
        end
      end else if (phase != PH_DONE) walk_attrs(b, p);
      if (pos < 16'hFFFF) pos++;
      if (eop) begin
        len = p + 1;
        verdict = 0;
        if (len >= 20 && hdr_ok && cookie_acc == COOKIE && mlen[1:0] == 0 &&
            20 + mlen <= len)
          verdict = (dport == port_reg) ? 2 : 1;
        add(K_VERDICT, verdict, 0);
        clear_packet();
      end
      if (run.size() > 0) run[run.size() - 1].last = 1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    function void check_record(logic [2:0] k, logic [63:0] v, logic [15:0] a, logic l);
      record_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected record kind=%0d value=%h aux=%h last=%b",
                 $time, k, v, a, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== k || e.value !== v || e.aux !== a || e.last !== l) begin
        $display("%0t: expected kind=%0d value=%h aux=%h last=%b, got %0d %h %h %b",
                 $time, e.kind, e.value, e.aux, e.last, k, v, a, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tlast = 0, out_tready = 0, cfg_valid = 0;
  logic [23:0] in_tdata = 0;
  logic [15:0] cfg_data = 0;
  logic        in_tready, out_tvalid, out_tlast, cfg_ready;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;

  stun_scoreboard board = new();
  bit          quiet = 0;   // no idling in the final stretch
  bit          hold_out = 0;
  int unsigned cycles = 0;
  int unsigned items = 0;

  always #4 clk = ~clk;

  stun_message_parser i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      board.note_byte(in_tdata[7:0], in_tlast, in_tdata[23:8]);
      items <= items + 1;
    end
    if (rst_n && out_tvalid && out_tready)
      board.check_record(out_tuser, out_tdata[63:0], out_tdata[79:64], out_tlast);
  end

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready <= 0;
        repeat (300) @(negedge clk);
        hold_out = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 10);
        repeat (n - 1) @(negedge clk);
      end else out_tready <= 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eop, logic [15:0] dport);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {dport, b};
    in_tlast <= eop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(logic [7:0] bytes[$], logic [15:0] dport);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, dport);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_port(logic [15:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.port_reg = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // build a header; attributes are appended by the caller
  function automatic void make_header(ref logic [7:0] q[$], input logic [15:0] mt,
                                      input logic [15:0] ml, input bit good_cookie);
    logic [31:0] ck;
    ck = good_cookie ? COOKIE : $urandom;
    q = {mt[15:8], mt[7:0], ml[15:8], ml[7:0], ck[31:24], ck[23:16], ck[15:8], ck[7:0]};
    repeat (12) q.push_back(8'($urandom));
  endfunction

  function automatic void add_attr(ref logic [7:0] q[$], input logic [15:0] at,
                                   input int len, input logic [7:0] fam);
    q.push_back(at[15:8]); q.push_back(at[7:0]);
    q.push_back(8'(len >> 8)); q.push_back(8'(len));
    for (int i = 0; i < len; i++) q.push_back((i == 1) ? fam : 8'($urandom));
    while (q.size() % 4 != 0) q.push_back(8'($urandom));
  endfunction

  // random, mostly well-formed message; sometimes broken afterwards
  task automatic random_message(logic [15:0] port_hint);
    logic [7:0]  q[$];
    logic [15:0] mt, dport;
    int          na, r;
    mt = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
         {8'($urandom_range(0, 1)), 8'($urandom_range(1, 9))};
    make_header(q, mt, 0, $urandom_range(0, 9) != 0);
    na = $urandom_range(0, 3);
    for (int i = 0; i < na; i++) begin
      r = $urandom_range(0, 3);
      if (r == 0) add_attr(q, ATYPE_USER, $urandom_range(0, 9), 0);
      else if (r == 1) add_attr(q, ATYPE_XMAP, $urandom_range(7, 12),
                                $urandom_range(0, 3) != 0 ? FAMILY_IPV4 : 8'h02);
      else add_attr(q, 16'($urandom), $urandom_range(0, 6), 0);
    end
    q[2] = 8'((q.size() - 20) >> 8);
    q[3] = 8'(q.size() - 20);
    r = $urandom_range(0, 9);
    if (r == 0 && q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
    else if (r == 1) q[3] = q[3] + 8'($urandom_range(1, 8));
    else if (r == 2) repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
    dport = $urandom_range(0, 1) ? port_hint : 16'($urandom);
    send_packet(q, dport);
  endtask

  initial begin
    logic [7:0] q[$];
    board.reset_all();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: short packet, extremes, username, mapped address and overrun
    send_packet({8'hFF}, 16'hFFFF);
    make_header(q, 16'h0001, 0, 1);
    send_packet(q, MATCH_PORT_RST);
    make_header(q, 16'h0109, 0, 1);
    add_attr(q, ATYPE_USER, 5, 0);
    add_attr(q, ATYPE_USER, 0, 0);
    add_attr(q, ATYPE_XMAP, 8, FAMILY_IPV4);
    q[3] = 8'(q.size() - 20);
    send_packet(q, 16'h0000);
    make_header(q, 16'hC0FF, 8, 1);
    add_attr(q, ATYPE_USER, 20, 0);   // overruns the declared length
    send_packet(q, MATCH_PORT_RST);

    write_port(16'h0000);
    make_header(q, 16'h0113, 0, 1);
    send_packet(q, 16'h0000);
    write_port(16'hFFFF);

    // long receiver hold while the sender keeps offering
    hold_out = 1;
    make_header(q, 16'h0101, 0, 1);
    add_attr(q, ATYPE_USER, 8, 0);
    q[3] = 8'(q.size() - 20);
    send_packet(q, 16'hFFFF);
    random_message(16'hFFFF);
    drain();   // sender pause until all records are back

    write_port(16'($urandom));
    while (items < 200) begin
      if ($urandom_range(0, 40) == 0) write_port(16'($urandom));
      random_message(board.port_reg);
    end
    quiet = 1;
    random_message(board.port_reg);
    write_port(MATCH_PORT_RST);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: files.f
sv/smp_pkg.sv
sv/smp_parser.sv
sv/smp_rec_fifo.sv
sv/stun_message_parser.sv
tb/sv/tb.sv
